[rtl/core/ldp_pkg.sv]
// ----------------------------------------------------------------------------
// ldp_pkg
// Shared widths, register codes and request/result types of the LD pair unit.
// ----------------------------------------------------------------------------
package ldp_pkg;

    localparam int COUNT_BITS    = 20;
    localparam int FRACTION_BITS = 16;
    localparam int PROD_BITS     = 2 * COUNT_BITS;
    localparam int WIDE_BITS     = 2 * PROD_BITS;
    localparam int Q_BITS        = FRACTION_BITS + 1;
    localparam int IDX_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ALLELE_TOTAL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RARE_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_DPRIME   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHARED_ONLY  = 2'd3;

    typedef struct packed {
        logic [IDX_BITS-1:0]   index_a;
        logic [IDX_BITS-1:0]   index_b;
        logic [COUNT_BITS-1:0] shared_count;
        logic [COUNT_BITS-1:0] count_a;
        logic [COUNT_BITS-1:0] count_b;
    } t_pair_req;

    typedef struct packed {
        logic [IDX_BITS-1:0]   pair_a;
        logic [IDX_BITS-1:0]   pair_b;
        logic [COUNT_BITS-1:0] shared_out;
        logic [Q_BITS-1:0]     dprime;
        logic [Q_BITS-1:0]     rsquared;
        logic                  degenerate;
    } t_pair_res;

endpackage

[rtl/core/ld_pair_dprime_rsquared_unit.sv]
// ----------------------------------------------------------------------------
// ld_pair_dprime_rsquared_unit
// Linkage disequilibrium D' and r squared of a variant pair, one pair a cycle while not stalled.
// ----------------------------------------------------------------------------
// Takes one pair request per cycle while the output is not stalled and returns
// its result through 5 arithmetic stages, 17 divider stages and 1 output
// register. Most of these stages lie in the two bit-per-stage dividers; a stall
// at the output freezes the whole pipeline. Skipped pairs leave no result.
module ld_pair_dprime_rsquared_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ldp_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [ldp_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  ldp_pkg::t_pair_req                  i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output ldp_pkg::t_pair_res                  o_data
);

    localparam int C  = ldp_pkg::COUNT_BITS;
    localparam int P  = ldp_pkg::PROD_BITS;
    localparam int W  = ldp_pkg::WIDE_BITS;
    localparam int F  = ldp_pkg::FRACTION_BITS;
    localparam int Q  = ldp_pkg::Q_BITS;
    localparam int IB = ldp_pkg::IDX_BITS;

    typedef struct packed {
        logic [IB-1:0] pair_a;
        logic [IB-1:0] pair_b;
        logic [C-1:0]  shared;
        logic          keep;
    } t_side;

    typedef struct packed {
        t_side side;
        logic  dzero;
        logic  degen;
    } t_tail;

    logic [C-1:0] r_allele_total;
    logic [C-1:0] r_rare_limit;
    logic [Q-1:0] r_min_dprime;
    logic         r_shared_only;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allele_total <= C'(2);
            r_rare_limit   <= '0;
            r_min_dprime   <= '0;
            r_shared_only  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ldp_pkg::CFG_ALLELE_TOTAL: r_allele_total <= i_cfg_data[C-1:0];
                ldp_pkg::CFG_RARE_LIMIT:   r_rare_limit   <= i_cfg_data[C-1:0];
                ldp_pkg::CFG_MIN_DPRIME:   r_min_dprime   <= i_cfg_data[Q-1:0];
                ldp_pkg::CFG_SHARED_ONLY:  r_shared_only  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage 1: clamp and complements
    logic         r1_v, r2_v, r3_v, r4_v, r5_v;
    t_side        r1_sd, r2_sd, r3_sd, r4_sd, r5_sd;
    logic [C-1:0] r1_n, r1_m, r1_a, r1_b, r1_na, r1_nb;
    logic [C-1:0] n_m, n_a, n_b;

    always_comb begin
        n_m = (i_data.shared_count > r_allele_total) ? r_allele_total : i_data.shared_count;
        n_a = (i_data.count_a > r_allele_total) ? r_allele_total : i_data.count_a;
        n_b = (i_data.count_b > r_allele_total) ? r_allele_total : i_data.count_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sd.pair_a <= i_data.index_a;
            r1_sd.pair_b <= i_data.index_b;
            r1_sd.shared <= i_data.shared_count;
            r1_sd.keep   <= (i_data.shared_count != '0) &&
                            !((i_data.count_a < r_rare_limit) &&
                              (i_data.count_b < r_rare_limit));
            r1_n  <= r_allele_total;
            r1_m  <= n_m;
            r1_a  <= n_a;
            r1_b  <= n_b;
            r1_na <= r_allele_total - n_a;
            r1_nb <= r_allele_total - n_b;
        end
    end

    // stage 2: products
    logic [P-1:0] r2_pos, r2_neg, r2_x1, r2_x2, r2_x3, r2_va, r2_vb;
    logic         r2_degen;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sd    <= r1_sd;
            r2_pos   <= r1_m * r1_n;
            r2_neg   <= r1_a * r1_b;
            r2_x1    <= r1_a * r1_nb;
            r2_x2    <= r1_na * r1_b;
            r2_x3    <= r1_na * r1_nb;
            r2_va    <= r1_a * r1_na;
            r2_vb    <= r1_b * r1_nb;
            r2_degen <= (r1_a == '0) || (r1_na == '0) || (r1_b == '0) || (r1_nb == '0);
        end
    end

    // stage 3: |D| and |Dmax|
    logic [P-1:0] r3_dabs, r3_dmax, r3_va, r3_vb;
    logic         r3_dzero, r3_degen;
    logic         positive;
    logic [P-1:0] n_dabs, n_dmax;

    always_comb begin
        positive = r2_pos > r2_neg;
        n_dabs   = positive ? r2_pos - r2_neg : r2_neg - r2_pos;
        if (positive) begin
            n_dmax = (r2_x1 < r2_x2) ? r2_x1 : r2_x2;
        end else begin
            n_dmax = (r2_neg < r2_x3) ? r2_neg : r2_x3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sd    <= r2_sd;
            r3_dabs  <= n_dabs;
            r3_dmax  <= n_dmax;
            r3_va    <= r2_va;
            r3_vb    <= r2_vb;
            r3_dzero <= (n_dabs == '0);
            r3_degen <= r2_degen;
        end
    end

    // stage 4: partial products of the wide terms
    logic [P-1:0] r4_sll, r4_slh, r4_shh;
    logic [P-1:0] r4_vll, r4_vlh, r4_vhl, r4_vhh;
    logic [P-1:0] r4_dabs, r4_dmax;
    logic         r4_dzero, r4_degen;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sd    <= r3_sd;
            r4_sll   <= r3_dabs[C-1:0] * r3_dabs[C-1:0];
            r4_slh   <= r3_dabs[C-1:0] * r3_dabs[P-1:C];
            r4_shh   <= r3_dabs[P-1:C] * r3_dabs[P-1:C];
            r4_vll   <= r3_va[C-1:0] * r3_vb[C-1:0];
            r4_vlh   <= r3_va[C-1:0] * r3_vb[P-1:C];
            r4_vhl   <= r3_va[P-1:C] * r3_vb[C-1:0];
            r4_vhh   <= r3_va[P-1:C] * r3_vb[P-1:C];
            r4_dabs  <= r3_dabs;
            r4_dmax  <= r3_dmax;
            r4_dzero <= r3_dzero;
            r4_degen <= r3_degen;
        end
    end

    // stage 5: wide sums
    logic [W-1:0] r5_num2, r5_den2;
    logic [P-1:0] r5_dabs, r5_dmax;
    logic         r5_dzero, r5_degen;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sd    <= r4_sd;
            r5_num2  <= {r4_shh, r4_sll} + (W'(r4_slh) << (C + 1));
            r5_den2  <= {r4_vhh, r4_vll} + (W'(r4_vlh) << C) + (W'(r4_vhl) << C);
            r5_dabs  <= r4_dabs;
            r5_dmax  <= r4_dmax;
            r5_dzero <= r4_dzero;
            r5_degen <= r4_degen;
        end
    end

    // divider stages
    logic [Q-1:0] dq, rq;

    ldp_qdiv #(.WIDTH(P), .FRAC(F)) u_div_d (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r5_dabs),
        .i_den (r5_dmax),
        .o_q   (dq)
    );

    ldp_qdiv #(.WIDTH(W), .FRAC(F)) u_div_r (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r5_num2),
        .i_den (r5_den2),
        .o_q   (rq)
    );

    logic  r_dv [0:F];
    t_tail r_tl [0:F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= F; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r5_v;
            for (int i = 1; i <= F; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tl[0] <= '{side: r5_sd, dzero: r5_dzero, degen: r5_degen};
            for (int i = 1; i <= F; i++) begin
                r_tl[i] <= r_tl[i-1];
            end
        end
    end

    // output register
    logic [Q-1:0] n_dq, n_rq;
    logic         n_keep;
    t_tail        tl;

    always_comb begin
        tl     = r_tl[F];
        n_dq   = (r_shared_only || tl.dzero) ? '0 : dq;
        n_rq   = (r_shared_only || tl.degen) ? '0 : rq;
        n_keep = tl.side.keep && (r_shared_only || (n_dq >= r_min_dprime));
    end

    logic r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_dv[F] && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_data.pair_a     <= tl.side.pair_a;
            o_data.pair_b     <= tl.side.pair_b;
            o_data.shared_out <= tl.side.shared;
            o_data.dprime     <= n_dq;
            o_data.rsquared   <= n_rq;
            o_data.degenerate <= tl.degen && !r_shared_only;
        end
    end

    assign o_valid = r_o_valid;

endmodule

[rtl/core/ldp_qdiv.sv]
// ----------------------------------------------------------------------------
// ldp_qdiv
// Pipelined restoring fraction divider, one quotient bit per stage,
// saturating at 1.0.
// ----------------------------------------------------------------------------
module ldp_qdiv #(
    parameter int WIDTH = 40,
    parameter int FRAC  = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    output logic [FRAC:0]    o_q
);

    logic [WIDTH-1:0] r_rem [0:FRAC-1];
    logic [WIDTH-1:0] r_den [0:FRAC-1];
    logic [FRAC-1:0]  r_q   [0:FRAC];
    logic             r_sat [0:FRAC];

    logic [WIDTH-1:0] n_rem [1:FRAC-1];
    logic             n_ge  [1:FRAC];

    always_comb begin
        logic [WIDTH:0] t;
        t = '0;
        for (int i = 1; i <= FRAC; i++) begin
            t = {r_rem[i-1], 1'b0};
            n_ge[i] = (t >= {1'b0, r_den[i-1]});
            if (i < FRAC) begin
                n_rem[i] = n_ge[i] ? WIDTH'(t - {1'b0, r_den[i-1]}) : t[WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_sat[0] <= (i_den == '0) || (i_num >= i_den);
            for (int i = 1; i <= FRAC; i++) begin
                if (i < FRAC) begin
                    r_rem[i] <= n_rem[i];
                    r_den[i] <= r_den[i-1];
                end
                r_q[i]   <= {r_q[i-1][FRAC-2:0], n_ge[i]};
                r_sat[i] <= r_sat[i-1];
            end
        end
    end

    assign o_q = r_sat[FRAC] ? {1'b1, {FRAC{1'b0}}} : {1'b0, r_q[FRAC]};

endmodule

[rtl/core/ldp_checker.sv]
// ----------------------------------------------------------------------------
// ldp_checker
// Port-level checks of the LD pair unit, bound to the top level.
// ----------------------------------------------------------------------------
module ldp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input ldp_pkg::t_pair_res                o_data
);

    localparam int F = ldp_pkg::FRACTION_BITS;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without an output stall");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_data))
        else $error("result changed while stalled");

    a_degen_r2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.degenerate) |-> (o_data.rsquared == '0))
        else $error("degenerate pair with nonzero r squared");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.dprime <= (1 << F)) && (o_data.rsquared <= (1 << F))))
        else $error("fraction above 1.0");

endmodule

bind ld_pair_dprime_rsquared_unit ldp_checker u_ldp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
